>>> rtl/lft_pkg.sv
package lft_pkg;

   // defaults for the top-level parameters
   localparam int LINE_BYTES_DEF = 256;
   localparam int MAX_FIELDS_DEF = 16;

   // result queue geometry; one word may push up to three results
   localparam int RQ_DEPTH = 8;
   localparam int RQ_PTR_W = 3;
   localparam int RQ_CNT_W = 4;
   localparam int MAX_PUSH = 3;

   // characters with a meaning to the scanner
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_NL   = 8'h0A;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_TAB  = 8'h09;

   // error codes carried in error results
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_LONG   = 2'd1;
   localparam logic [1:0] ERR_FIELDS = 2'd2;

   // finished status: running, latched error, or stream ended
   localparam logic [1:0] FIN_RUN    = 2'd0;
   localparam logic [1:0] FIN_LONG   = 2'd1;
   localparam logic [1:0] FIN_FIELDS = 2'd2;
   localparam logic [1:0] FIN_END    = 2'd3;

   typedef enum logic [2:0] {
      K_CHAR  = 3'd0,
      K_FEND  = 3'd1,
      K_LEND  = 3'd2,
      K_ERROR = 3'd3,
      K_EOS   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      SC_BEGIN   = 3'd0,
      SC_DASH    = 3'd1,
      SC_COMMENT = 3'd2,
      SC_FIELD   = 3'd3,
      SC_AFTER   = 3'd4,
      SC_FRESH   = 3'd5
   } scan_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_value;
      logic [3:0]  field_index;
      logic [23:0] line_number;
      logic [4:0]  field_count;
      logic        leading_space;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

   // results of one accepted word, handed from the scanner to the queue
   typedef struct packed {
      rsp_type [MAX_PUSH-1:0] item;
      logic [1:0]             count;
   } push_type;

endpackage

>>> rtl/lft_core.sv
module lft_core #(
   parameter int LINE_BYTES = lft_pkg::LINE_BYTES_DEF,
   parameter int MAX_FIELDS = lft_pkg::MAX_FIELDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  lft_pkg::req_type  req_word,
   output lft_pkg::push_type push
);

   localparam int PW = $clog2(LINE_BYTES + 1);
   localparam int FW = $clog2(MAX_FIELDS + 1);
   localparam logic [23:0] LINE_TOP = 24'hFFFFFF;

   typedef struct packed {
      lft_pkg::scan_type scan;
      logic [PW-1:0]     pos;
      logic [FW-1:0]     fields;
      logic [23:0]       line;
      logic              lead;
      logic [1:0]        fin;
   } st_type;

   typedef struct packed {
      st_type                                 st;
      lft_pkg::rsp_type [lft_pkg::MAX_PUSH-1:0] res;
      logic [1:0]                             n;
      logic                                   ok;
   } wk_type;

   st_type state_ff;
   st_type state_in;
   wk_type w;

   function automatic logic is_blank(logic [7:0] c);
      return (c == lft_pkg::CH_SP) || (c == lft_pkg::CH_TAB);
   endfunction

   function automatic wk_type emit(wk_type wi, lft_pkg::kind_type kind, logic [7:0] ch,
                                   logic [1:0] err);
      lft_pkg::rsp_type r;
      wk_type           o;
      o               = wi;
      r.kind          = kind;
      r.char_value    = ch;
      r.field_index   = (kind == lft_pkg::K_CHAR || kind == lft_pkg::K_FEND) ?
                        4'(wi.st.fields) : 4'd0;
      r.line_number   = wi.st.line;
      r.field_count   = 5'(wi.st.fields);
      r.leading_space = wi.st.lead;
      r.error_code    = err;
      r.last          = 1'b0;
      o.res[wi.n]     = r;
      o.n             = wi.n + 2'd1;
      return o;
   endfunction

   function automatic wk_type fail(wk_type wi, logic [1:0] code);
      wk_type o;
      o        = wi;
      o.st.fin = code;
      o        = emit(o, lft_pkg::K_ERROR, 8'd0, code);
      o.ok     = 1'b0;
      return o;
   endfunction

   function automatic wk_type put_char(wk_type wi, logic [7:0] ch);
      wk_type o;
      o = wi;
      if (wi.ok) begin
         if (wi.st.pos >= PW'(LINE_BYTES)) begin
            o = fail(o, lft_pkg::ERR_LONG);
         end else begin
            o.st.pos = wi.st.pos + PW'(1);
            o        = emit(o, lft_pkg::K_CHAR, ch, lft_pkg::ERR_NONE);
         end
      end
      return o;
   endfunction

   function automatic wk_type close_field(wk_type wi);
      wk_type o;
      o = wi;
      if (wi.ok) begin
         if (wi.st.pos >= PW'(LINE_BYTES)) begin
            o = fail(o, lft_pkg::ERR_LONG);
         end else begin
            o.st.pos    = wi.st.pos + PW'(1);
            o           = emit(o, lft_pkg::K_FEND, 8'd0, lft_pkg::ERR_NONE);
            o.st.fields = wi.st.fields + FW'(1);
         end
      end
      return o;
   endfunction

   function automatic wk_type open_field(wk_type wi, logic [7:0] ch);
      wk_type o;
      o = wi;
      if (wi.ok) begin
         if (wi.st.fields >= FW'(MAX_FIELDS)) begin
            o = fail(o, lft_pkg::ERR_FIELDS);
         end else begin
            o = put_char(o, ch);
         end
      end
      return o;
   endfunction

   function automatic wk_type line_done(wk_type wi);
      wk_type o;
      o = wi;
      if (wi.ok) begin
         o         = emit(o, lft_pkg::K_LEND, 8'd0, lft_pkg::ERR_NONE);
         o.st.scan = lft_pkg::SC_FRESH;
      end
      return o;
   endfunction

   function automatic wk_type bump_line(wk_type wi);
      wk_type o;
      o = wi;
      if (wi.st.line != LINE_TOP) begin
         o.st.line = wi.st.line + 24'd1;
      end
      return o;
   endfunction

   // one byte or end mark through the scanner
   always_comb begin
      logic [7:0] c;
      c    = req_word.data_byte;
      w    = '0;
      w.st = state_ff;
      w.ok = 1'b1;
      if (state_ff.fin == lft_pkg::FIN_RUN) begin
         if (!(w.st.scan inside {lft_pkg::SC_BEGIN, lft_pkg::SC_DASH, lft_pkg::SC_COMMENT,
                                 lft_pkg::SC_FIELD, lft_pkg::SC_AFTER})) begin
            w         = bump_line(w);
            w.st.pos  = '0;
            w.st.fields = '0;
            w.st.lead = 1'b0;
            w.st.scan = lft_pkg::SC_BEGIN;
         end
         if (req_word.end_of_input) begin
            case (w.st.scan)
               lft_pkg::SC_DASH: begin
                  w = open_field(w, lft_pkg::CH_DASH);
                  w = close_field(w);
               end
               lft_pkg::SC_FIELD: begin
                  w = close_field(w);
               end
               default: begin
               end
            endcase
            if (w.ok) begin
               w.st.fin = lft_pkg::FIN_END;
               w        = emit(w, lft_pkg::K_EOS, 8'd0, lft_pkg::ERR_NONE);
            end
         end else begin
            case (w.st.scan)
               lft_pkg::SC_BEGIN: begin
                  if (is_blank(c)) begin
                     w.st.lead = 1'b1;
                  end else if (c == lft_pkg::CH_NL) begin
                     w.st.lead = 1'b0;
                     w         = bump_line(w);
                  end else if (c == lft_pkg::CH_DASH) begin
                     w.st.scan = lft_pkg::SC_DASH;
                  end else begin
                     w = open_field(w, c);
                     if (w.ok) w.st.scan = lft_pkg::SC_FIELD;
                  end
               end
               lft_pkg::SC_DASH: begin
                  if (c == lft_pkg::CH_DASH) begin
                     w.st.scan = lft_pkg::SC_COMMENT;
                  end else begin
                     w = open_field(w, lft_pkg::CH_DASH);
                     if (is_blank(c) || c == lft_pkg::CH_NL) begin
                        w = close_field(w);
                        if (c == lft_pkg::CH_NL) begin
                           w = line_done(w);
                        end else if (w.ok) begin
                           w.st.scan = lft_pkg::SC_AFTER;
                        end
                     end else begin
                        w = put_char(w, c);
                        if (w.ok) w.st.scan = lft_pkg::SC_FIELD;
                     end
                  end
               end
               lft_pkg::SC_COMMENT: begin
                  if (c == lft_pkg::CH_NL) begin
                     if (w.st.fields != '0) begin
                        w = line_done(w);
                     end else begin
                        w.st.lead = 1'b0;
                        w         = bump_line(w);
                        w.st.scan = lft_pkg::SC_BEGIN;
                     end
                  end
               end
               lft_pkg::SC_FIELD: begin
                  if (is_blank(c)) begin
                     w = close_field(w);
                     if (w.ok) w.st.scan = lft_pkg::SC_AFTER;
                  end else if (c == lft_pkg::CH_NL) begin
                     w = close_field(w);
                     w = line_done(w);
                  end else begin
                     w = put_char(w, c);
                  end
               end
               default: begin
                  // between fields
                  if (is_blank(c)) begin
                     w.st.lead = w.st.lead;
                  end else if (c == lft_pkg::CH_NL) begin
                     w = line_done(w);
                  end else if (c == lft_pkg::CH_DASH) begin
                     w.st.scan = lft_pkg::SC_DASH;
                  end else begin
                     w = open_field(w, c);
                     if (w.ok) w.st.scan = lft_pkg::SC_FIELD;
                  end
               end
            endcase
         end
      end
      if (w.n != 2'd0) begin
         w.res[w.n - 2'd1].last = 1'b1;
      end
   end

   assign state_in   = accept ? w.st : state_ff;
   assign push.item  = w.res;
   assign push.count = accept ? w.n : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.scan   <= lft_pkg::SC_FRESH;
         state_ff.pos    <= '0;
         state_ff.fields <= '0;
         state_ff.line   <= '0;
         state_ff.lead   <= 1'b0;
         state_ff.fin    <= lft_pkg::FIN_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/lft_queue.sv
module lft_queue (
   input  logic              clock,
   input  logic              reset,
   input  lft_pkg::push_type push,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lft_pkg::rsp_type  rsp_word
);

   localparam logic [lft_pkg::RQ_CNT_W-1:0] FULL_MARK =
      lft_pkg::RQ_CNT_W'(lft_pkg::RQ_DEPTH - lft_pkg::MAX_PUSH);

   lft_pkg::rsp_type entry_ff [lft_pkg::RQ_DEPTH];
   logic [lft_pkg::RQ_PTR_W-1:0] head_ff, head_in;
   logic [lft_pkg::RQ_PTR_W-1:0] tail_ff, tail_in;
   logic [lft_pkg::RQ_CNT_W-1:0] count_ff, count_in;
   logic                         pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entry_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for a full burst must exist before a word is taken
   assign full      = (count_ff > FULL_MARK);

   assign head_in  = pop ? head_ff + lft_pkg::RQ_PTR_W'(1) : head_ff;
   assign tail_in  = tail_ff + lft_pkg::RQ_PTR_W'(push.count);
   assign count_in = count_ff + lft_pkg::RQ_CNT_W'(push.count)
                     - lft_pkg::RQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < lft_pkg::MAX_PUSH; i++) begin
         if (2'(i) < push.count) begin
            entry_ff[tail_ff + lft_pkg::RQ_PTR_W'(i)] <= push.item[i];
         end
      end
   end

endmodule

>>> rtl/line_field_tokenizer_unit.sv
// Channel   Direction  Handshake              Word
// req_      in         req_valid / req_stall  lft_pkg::req_type  (byte, end mark)
// rsp_      out        rsp_valid / rsp_stall  lft_pkg::rsp_type  (one result)
//
// One input word is taken per cycle unless stalled; its zero to three results are
// written into an eight-entry queue in the same cycle and leave it one per cycle while
// rsp_stall is low. Sustained rate is one word per cycle while each word yields at
// most one result and rsp_stall is low; the one-result-per-cycle queue read port sets
// the rate during bursts. req_stall rises when fewer than three queue entries are free.
// Reset is synchronous: fresh line, counters cleared, no error, queue empty.
// After an error or the end-of-stream result, words are still taken but yield nothing.
module line_field_tokenizer_unit #(
   parameter int LINE_BYTES = lft_pkg::LINE_BYTES_DEF,
   parameter int MAX_FIELDS = lft_pkg::MAX_FIELDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lft_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lft_pkg::rsp_type rsp_word
);

   logic              accept;
   logic              queue_full;
   lft_pkg::push_type push;

   // stall comes from the registered queue level only
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // scanner: line/field state registers and the per-word result logic
   lft_core #(
      .LINE_BYTES (LINE_BYTES),
      .MAX_FIELDS (MAX_FIELDS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .push     (push)
   );

   // result queue: multi-entry write, single read toward the rsp_ side
   lft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
